// ===== hw/rtl/multi_beep_sequencer_core_defines.svh =====
// Assertion helpers for the beep sequencer.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef MULTI_BEEP_SEQUENCER_CORE_DEFINES_SVH
`define MULTI_BEEP_SEQUENCER_CORE_DEFINES_SVH

// Condition must hold at every clock edge.
`define MBS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger implies the consequence in the next cycle.
`define MBS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mbs_pkg.sv =====
package mbs_pkg;

  // Default parameter values.
  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned CountBitsDefault = 4;

  // Fixed field widths.
  localparam int unsigned ReqW       = 3;
  localparam int unsigned AmountW    = 16;
  localparam int unsigned CountInW   = 8;
  localparam int unsigned GapW       = 16;
  localparam int unsigned MaxBeepsW  = 4;
  localparam int unsigned RemainW    = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 8;

  // Register reset values.
  localparam logic [GapW-1:0]      FastGapReset    = 16'd150;
  localparam logic [GapW-1:0]      SlowGapReset    = 16'd1000;
  localparam logic [GapW-1:0]      NormalBeepReset = 16'd100;
  localparam logic [MaxBeepsW-1:0] MaxBeepsReset   = 4'd15;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK     = 3'd0,
    REQ_TIMED    = 3'd1,
    REQ_PERIODIC = 3'd2,
    REQ_START    = 3'd3,
    REQ_STOP     = 3'd4
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_GAP    = 2'd0,
    CFG_SLOW_GAP    = 2'd1,
    CFG_NORMAL_BEEP = 2'd2,
    CFG_MAX_BEEPS   = 2'd3
  } cfg_index_e;

  // Result item.
  typedef struct packed {
    logic               button_lockout;
    logic [RemainW-1:0] beeps_remaining;
    logic               sequence_active;
    logic               buzzer_on;
  } result_t;

endpackage

// ===== hw/rtl/multi_beep_sequencer_core.sv =====
// Buzzer pattern sequencer.
// Slave stream s_axis_*: one request per transaction. tuser carries the request
// kind (tick, timed beep, periodic beep, start sequence, stop); tdata carries
// the elapsed time or beep length, the fast-gap select and the beep count.
// Master stream m_axis_*: exactly one status transaction per request, showing
// buzzer level, sequence activity, beeps left and button lockout after it.
// cfg_*: register writes (gap reloads, periodic beep length, beep limit);
// always ready; write only while no request is in flight (not enforced here).
// A request passes through the input register, then the state update and result
// register. One request per cycle while the receiver takes results; the state
// update is a single subtract-and-compare pass on the countdowns.
// Reset clears the countdowns and sequence state, silences the buzzer, empties
// both stages and restores register defaults.
// A stalled receiver holds the result register; the input register still
// fills, and s_axis_tready_o drops only once both stages are full.
`include "multi_beep_sequencer_core_defines.svh"

module multi_beep_sequencer_core
  import mbs_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDefault,
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: time_amount[15:0], fast_select[16], beep_count[24:17], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: req_type[2:0]
  input  logic [ReqW-1:0]     s_axis_tuser_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: buzzer_on[0], sequence_active[1], beeps_remaining[5:2],
  //        button_lockout[6], zero pad [7]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Compare width covering both the countdowns and the 16-bit fields.
  localparam int unsigned CmpW = (TIMER_BITS > AmountW) ? TIMER_BITS : AmountW;
  localparam logic [CmpW-1:0]     TimerMaxCmp = CmpW'({TIMER_BITS{1'b1}});
  localparam logic [CountInW-1:0] CountMax8   = CountInW'({COUNT_BITS{1'b1}});

  // Saturate a 16-bit reload value into a countdown.
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [AmountW-1:0] v);
    logic [CmpW-1:0] w;
    w = CmpW'(v);
    if (w > TimerMaxCmp) begin
      return {TIMER_BITS{1'b1}};
    end else begin
      return w[TIMER_BITS-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GapW-1:0]      fast_gap_q, slow_gap_q, normal_beep_q;
  logic [MaxBeepsW-1:0] max_beeps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_gap_q    <= FastGapReset;
      slow_gap_q    <= SlowGapReset;
      normal_beep_q <= NormalBeepReset;
      max_beeps_q   <= MaxBeepsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FAST_GAP:    fast_gap_q    <= cfg_data_i;
        CFG_SLOW_GAP:    slow_gap_q    <= cfg_data_i;
        CFG_NORMAL_BEEP: normal_beep_q <= cfg_data_i;
        CFG_MAX_BEEPS:   max_beeps_q   <= cfg_data_i[MaxBeepsW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                in_valid_q;
  logic [ReqW-1:0]     req_q;
  logic [AmountW-1:0]  amount_q;
  logic                fast_sel_q;
  logic [CountInW-1:0] count_in_q;

  logic out_valid_q;
  logic advance;

  // Move the held request into the state update when the result slot frees.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q      <= s_axis_tuser_i;
      amount_q   <= s_axis_tdata_i[AmountW-1:0];
      fast_sel_q <= s_axis_tdata_i[AmountW];
      count_in_q <= s_axis_tdata_i[AmountW+1 +: CountInW];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [TIMER_BITS-1:0] beep_cd_q, beep_cd_d;
  logic [TIMER_BITS-1:0] gap_cd_q, gap_cd_d;
  logic                  seq_en_q, seq_en_d;
  logic                  phase_q, phase_d;
  logic                  fast_q, fast_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic                  buzz_q, buzz_d;

  logic [CmpW-1:0]       elapsed_w, beep_w, gap_w;
  logic [COUNT_BITS-1:0] left_dec;
  logic [CountInW-1:0]   lim8, count_clamped;

  always_comb begin
    beep_cd_d = beep_cd_q;
    gap_cd_d  = gap_cd_q;
    seq_en_d  = seq_en_q;
    phase_d   = phase_q;
    fast_d    = fast_q;
    left_d    = left_q;
    buzz_d    = buzz_q;

    elapsed_w = CmpW'(amount_q);
    beep_w    = CmpW'(beep_cd_q);
    gap_w     = CmpW'(gap_cd_q);
    left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;

    // Clamp the requested count to max_beeps (zero acts as one) and the counter.
    lim8 = (max_beeps_q == '0) ? CountInW'(1) : CountInW'(max_beeps_q);
    if (lim8 > CountMax8) begin
      lim8 = CountMax8;
    end
    count_clamped = (count_in_q > lim8) ? lim8 : count_in_q;

    unique case (req_q)
      REQ_TICK: begin
        // Run down the beep timer; it silences the buzzer outside a beep phase.
        if (beep_cd_q != '0) begin
          if (beep_w > elapsed_w) begin
            beep_cd_d = TIMER_BITS'(beep_w - elapsed_w);
          end else begin
            beep_cd_d = '0;
            if (!phase_q) begin
              buzz_d = 1'b0;
            end
          end
        end
        gap_cd_d = (gap_w > elapsed_w) ? TIMER_BITS'(gap_w - elapsed_w) : '0;

        // One sequencing step when the gap has run out.
        if (seq_en_q && (gap_cd_d == '0)) begin
          if (phase_q) begin
            if (beep_cd_d == '0) begin
              buzz_d = 1'b0;
            end
            if (left_dec == '0) begin
              seq_en_d = 1'b0;
              phase_d  = 1'b0;
              fast_d   = 1'b0;
              left_d   = '0;
            end else begin
              left_d  = left_dec;
              phase_d = 1'b0;
            end
          end else begin
            phase_d = 1'b1;
            buzz_d  = 1'b1;
          end
          // Reload from the mode left by this step; a finished run gets slow.
          gap_cd_d = sat_load(fast_d ? fast_gap_q : slow_gap_q);
        end
      end
      REQ_TIMED: begin
        beep_cd_d = sat_load(amount_q);
        buzz_d    = 1'b1;
      end
      REQ_PERIODIC: begin
        if (beep_cd_q == '0) begin
          beep_cd_d = sat_load(normal_beep_q);
          buzz_d    = 1'b1;
        end
      end
      REQ_START: begin
        if (count_in_q != '0) begin
          seq_en_d = 1'b1;
          phase_d  = 1'b1;
          fast_d   = fast_sel_q;
          left_d   = count_clamped[COUNT_BITS-1:0];
          gap_cd_d = sat_load(fast_sel_q ? fast_gap_q : slow_gap_q);
          buzz_d   = 1'b1;
        end
      end
      REQ_STOP: begin
        if ((beep_cd_q == '0) && phase_q) begin
          buzz_d = 1'b0;
        end
        seq_en_d = 1'b0;
        phase_d  = 1'b0;
        fast_d   = 1'b0;
        left_d   = '0;
      end
      default: ;  // unknown request kinds leave the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_cd_q <= '0;
      gap_cd_q  <= '0;
      seq_en_q  <= 1'b0;
      phase_q   <= 1'b0;
      fast_q    <= 1'b0;
      left_q    <= '0;
      buzz_q    <= 1'b0;
    end else if (advance) begin
      beep_cd_q <= beep_cd_d;
      gap_cd_q  <= gap_cd_d;
      seq_en_q  <= seq_en_d;
      phase_q   <= phase_d;
      fast_q    <= fast_d;
      left_q    <= left_d;
      buzz_q    <= buzz_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  result_t             res_d, res_q;
  logic [CountInW-1:0] left_wide;

  always_comb begin
    left_wide             = CountInW'(left_d);
    res_d.buzzer_on       = buzz_d;
    res_d.sequence_active = seq_en_d;
    res_d.beeps_remaining = left_wide[RemainW-1:0];
    res_d.button_lockout  = (beep_cd_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(res_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MBS_ASSERT(a_seq_has_beeps, !seq_en_q || (left_q != '0), "running sequence with no beeps left")
  `MBS_ASSERT(a_idle_seq_clear, seq_en_q || (!phase_q && !fast_q && (left_q == '0)), "stale sequence state while idle")
  `MBS_ASSERT_NEXT(a_result_follows, advance, out_valid_q, "state update without a result")

endmodule
